/* hw/rtl/pkh_pkg.sv */
// shared types and constants of the pair key hash table
package pkh_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 16;

    localparam logic [31:0] MIX_MUL = 32'h045d9f3b;
    localparam int MIX_SHIFT = 16;
    localparam int LOAD_SCALE = 100;

    localparam int SLOT_W = 10;
    localparam int CONTACT_W = 8;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 7'd70;

    // apb register map, one 32-bit word per register
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LOAD_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_SET     = 2'd1,
        CMD_GET_INS = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_DONE
    } back_state_t;

endpackage

/* hw/rtl/pkh_req_if.sv */
// request channel of the pair key hash table
interface pkh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] key_i;
    logic [15:0] key_j;
    logic [7:0]  contact_count;

    modport source (output valid, cmd, key_i, key_j, contact_count, input ready);
    modport sink (input valid, cmd, key_i, key_j, contact_count, output ready);
endinterface

/* hw/rtl/pkh_rsp_if.sv */
// response channel of the pair key hash table
interface pkh_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] slot_index;
    logic [7:0] stored_contacts;

    modport source (output valid, status, slot_index, stored_contacts, input ready);
    modport sink (input valid, status, slot_index, stored_contacts, output ready);
endinterface

/* hw/rtl/pkh_ram.sv */
// generic simple dual port ram with registered read
module pkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/pkh_queue.sv */
// two entry queue between hash front and probe back
module pkh_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hw/rtl/pkh_front.sv */
// hash front: accepts requests, mixes the key, reduces to a start slot
module pkh_front
    import pkh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pkh_req_if.sink req,
    output logic out_valid,
    input  logic out_ready,
    output logic [2+2*KEY_BITS+CONTACT_W+$clog2(CAPACITY)-1:0] out_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int TAG_W = 2 + 2 * KEY_BITS + CONTACT_W;
    localparam int NSTG  = 6;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);

    function automatic logic [31:0] fold(input logic [31:0] h);
        fold = (h >> MIX_SHIFT) ^ h;
    endfunction

    logic [NSTG-1:0]  v_reg;
    logic [TAG_W-1:0] tag_reg [NSTG];
    logic [31:0] k1_reg, h2_reg, h3_reg, hf4_reg, q4_reg, hf5_reg, pr5_reg;
    logic [IDX_W-1:0] r6_reg;
    logic en;
    logic [KEY_BITS-1:0] ki_m, kj_m;
    logic [TAG_W-1:0] tag_in;
    logic [63:0] qprod;
    logic [63:0] cprod;
    logic [31:0] diff, r_next;

    assign en        = !(v_reg[NSTG-1] && !out_ready);
    assign req.ready = en;
    assign out_valid = v_reg[NSTG-1];
    assign out_data  = {tag_reg[NSTG-1], r6_reg};

    always_comb
    begin
        ki_m   = req.key_i[KEY_BITS-1:0];
        kj_m   = req.key_j[KEY_BITS-1:0];
        tag_in = {req.cmd, ki_m, kj_m, req.contact_count};
        // floor(h * 2^32 / c) / 2^32 undershoots the quotient by at most one
        qprod  = 64'(fold(h3_reg)) * 64'(RECIP);
        cprod  = 64'(q4_reg) * 64'(CAPACITY);
        diff   = hf5_reg - pr5_reg;
        r_next = (diff >= 32'(CAPACITY)) ? diff - 32'(CAPACITY) : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTG-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int s = 1; s < NSTG; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            k1_reg  <= 32'(kj_m) * 32'(kj_m) + 32'(ki_m);
            h2_reg  <= fold(k1_reg) * MIX_MUL;
            h3_reg  <= fold(h2_reg) * MIX_MUL;
            hf4_reg <= fold(h3_reg);
            q4_reg  <= qprod[63:32];
            hf5_reg <= hf4_reg;
            pr5_reg <= cprod[31:0];
            r6_reg  <= IDX_W'(r_next);
        end
    end

endmodule

/* hw/rtl/pkh_back.sv */
// probe back: clears the slot store, walks slots linearly, applies the command
module pkh_back
    import pkh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  logic [2+2*KEY_BITS+CONTACT_W+$clog2(CAPACITY)-1:0] q_data,
    input  logic [LIMIT_W-1:0] load_limit,
    pkh_rsp_if.source rsp
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ENT_W  = 2 + 2 * KEY_BITS + CONTACT_W;
    localparam int LOAD_W = CNT_W + LIMIT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0]     clr_reg;
    cmd_t                 cmd_reg;
    logic [KEY_BITS-1:0]  ki_reg, kj_reg;
    logic [CONTACT_W-1:0] cc_reg;
    logic [IDX_W-1:0]     idx_reg, step_reg, tomb_reg;
    logic                 have_tomb_reg;
    logic [CNT_W-1:0]     used_reg;
    status_t              status_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [CONTACT_W-1:0] contacts_reg;

    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [ENT_W-1:0]     wdata, rdata;

    logic                 e_occ, e_tomb;
    logic [KEY_BITS-1:0]  e_ki, e_kj;
    logic [CONTACT_W-1:0] e_cc;
    logic match, empty, last, tomb_now, eff_have, finish, got, fresh, load_full;
    logic [IDX_W-1:0]     where_idx;
    status_t              res_status;
    logic [IDX_W-1:0]     res_slot;
    logic [CONTACT_W-1:0] res_contacts;
    logic                 res_we, used_inc;
    logic [ENT_W-1:0]     res_wdata;
    logic [LOAD_W-1:0]    load_num, load_lim;

    pkh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // probe step evaluation and command outcome
    always_comb
    begin
        {e_occ, e_tomb, e_ki, e_kj, e_cc} = rdata;
        match     = e_occ && (e_ki == ki_reg) && (e_kj == kj_reg);
        empty     = !e_occ && !e_tomb;
        last      = (step_reg == LAST_IDX);
        tomb_now  = !e_occ && e_tomb && !have_tomb_reg;
        eff_have  = have_tomb_reg || tomb_now;
        finish    = match || empty || last;
        got       = match || empty || eff_have;
        where_idx = match ? idx_reg : (have_tomb_reg ? tomb_reg : idx_reg);
        fresh     = !eff_have;
        load_num  = (LOAD_W'(used_reg) + LOAD_W'(1)) * LOAD_W'(LOAD_SCALE);
        load_lim  = LOAD_W'(load_limit) * LOAD_W'(CAPACITY);
        load_full = (load_num >= load_lim);

        res_status   = ST_NOT_FOUND;
        res_slot     = '0;
        res_contacts = '0;
        res_we       = 1'b0;
        res_wdata    = {1'b1, 1'b0, ki_reg, kj_reg, cc_reg};
        used_inc     = 1'b0;
        case (cmd_reg)
            CMD_GET, CMD_REMOVE:
            begin
                if (match)
                begin
                    res_status   = ST_FOUND;
                    res_slot     = idx_reg;
                    res_contacts = e_cc;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        res_we    = 1'b1;
                        res_wdata = {1'b0, 1'b1, e_ki, e_kj, e_cc};
                    end
                end
            end
            default:
            begin
                if (match)
                begin
                    res_status   = ST_FOUND;
                    res_slot     = idx_reg;
                    res_contacts = (cmd_reg == CMD_SET) ? cc_reg : e_cc;
                    res_we       = (cmd_reg == CMD_SET);
                end
                else if (!got || (fresh && load_full))
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status   = ST_INSERTED;
                    res_slot     = where_idx;
                    res_contacts = cc_reg;
                    res_we       = 1'b1;
                    used_inc     = fresh;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: if (clr_reg == LAST_IDX) state_next = BK_IDLE;
            BK_IDLE:  if (q_valid) state_next = BK_READ;
            BK_READ:  state_next = BK_CHECK;
            BK_CHECK: state_next = finish ? BK_DONE : BK_READ;
            BK_DONE:  if (rsp.ready) state_next = BK_IDLE;
            default:  state_next = BK_CLEAR;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == BK_IDLE);
        rsp.valid = (state_reg == BK_DONE);
        raddr     = idx_reg;
        we        = 1'b0;
        waddr     = where_idx;
        wdata     = res_wdata;
        case (state_reg)
            BK_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            BK_CHECK:
            begin
                we = finish && res_we;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign rsp.status          = status_reg;
    assign rsp.slot_index      = SLOT_W'(slot_reg);
    assign rsp.stored_contacts = contacts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (state_reg == BK_CHECK && finish && used_inc)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cmd_reg <= cmd_t'(q_data[ENT_W+IDX_W-1 -: 2]);
                {ki_reg, kj_reg, cc_reg, idx_reg} <= q_data[ENT_W+IDX_W-3:0];
                step_reg      <= '0;
                have_tomb_reg <= 1'b0;
                tomb_reg      <= '0;
            end
            BK_CHECK:
            begin
                if (tomb_now)
                begin
                    have_tomb_reg <= 1'b1;
                    tomb_reg      <= idx_reg;
                end
                idx_reg  <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                step_reg <= step_reg + IDX_W'(1);
                if (finish)
                begin
                    status_reg   <= res_status;
                    slot_reg     <= res_slot;
                    contacts_reg <= res_contacts;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/pair_key_hash_table.sv */
// top level: pair key hash table with apb load limit register
// path: hash pipeline, then the queue, then the probe unit, which visits p slots
//   (1 to CAPACITY) per request and takes the next request only when done;
// the single read port of the slot memory makes it read, then check, each
//   probed slot in turn
// reset: control cleared at once; then a clearing pass zeroes the slot memory,
//   during which no request reaches the probe unit
module pair_key_hash_table
    import pkh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pkh_req_if.sink               req,
    pkh_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // queue entry: command, both keys, contact count, start slot
    localparam int QW = 2 + 2 * KEY_BITS + CONTACT_W + $clog2(CAPACITY);

    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_sel;

    logic          f_valid, f_ready;
    logic [QW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [QW-1:0] b_data;

    // register index is the word address; byte offset bits are ignored
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_LOAD_LIMIT)
        begin
            prdata = APB_DATA_W'(limit_reg);
        end
    end

    // write lands on the access cycle; the user must change the limit only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LOAD_LIMIT_RST;
        end
        else if (psel && penable && pwrite && reg_sel == REG_LOAD_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // hash front: keeps taking requests while the back is probing, until the queue and its pipeline fill
    pkh_front #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // decouples hashing from probing
    pkh_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    // probe unit owns the slot memory and the used slot count
    pkh_back #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (b_valid),
        .q_ready    (b_ready),
        .q_data     (b_data),
        .load_limit (limit_reg),
        .rsp        (rsp)
    );

endmodule

/* hw/rtl/pkh_checker.sv */
// port level checks of the pair key hash table and their bind
module pkh_checker
    import pkh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [9:0]  slot_index,
    input logic [7:0]  stored_contacts,
    input logic [31:0] prdata
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(slot_index) && $stable(stored_contacts))
        else $error("response changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL)
            |-> slot_index == '0 && stored_contacts == '0)
        else $error("miss or full carries nonzero fields");

    a_prdata_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:LIMIT_W] == '0)
        else $error("register read has bits above the load limit");

endmodule

bind pair_key_hash_table pkh_checker u_pkh_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .slot_index      (rsp.slot_index),
    .stored_contacts (rsp.stored_contacts),
    .prdata          (prdata)
);

/* bench/pair_key_hash_table_tb.sv */
// testbench for the pair key hash table: request stimulus, predictor and response checks
`timescale 1ns / 100ps

module pair_key_hash_table_tb;
    import pkh_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int IDLE_LIMIT = 40000;   // covers the clearing pass and long probe runs
    localparam int POOL_SIZE  = 48;

    typedef struct {
        status_t    status;
        logic [9:0] slot_index;
        logic [7:0] contacts;
    } table_result_t;

    // shadow copy of the slot store with its expected responses
    class pair_table_scoreboard;
        bit              occupied[SLOTS];
        bit              tombstone[SLOTS];
        logic [15:0]     owner_i[SLOTS];
        logic [15:0]     owner_j[SLOTS];
        logic [7:0]      held_contacts[SLOTS];
        int unsigned     used_slots;
        int unsigned     load_limit;
        table_result_t   awaited[$];
        int              errors;
        int              checked;
        int              status_seen[4];

        function new();
            for (int s = 0; s < SLOTS; s++)
            begin
                occupied[s] = 0;
                tombstone[s] = 0;
            end
            used_slots = 0;
            load_limit = LOAD_LIMIT_RST;
            errors = 0;
            checked = 0;
            foreach (status_seen[n])
                status_seen[n] = 0;
        endfunction

        function logic [31:0] pair_hash(logic [15:0] ki, logic [15:0] kj);
            logic [31:0] k;
            logic [31:0] h;
            k = {16'd0, kj} * {16'd0, kj} + {16'd0, ki};
            h = ((k >> MIX_SHIFT) ^ k) * MIX_MUL;
            h = ((h >> MIX_SHIFT) ^ h) * MIX_MUL;
            return (h >> MIX_SHIFT) ^ h;
        endfunction

        // walk one lap; picks a match, else first tombstone, else first never-used slot
        function bit find_slot(logic [15:0] ki, logic [15:0] kj, output int where,
                               output bit hit);
            int  idx;
            bit  have_tomb;
            int  tomb;
            idx = pair_hash(ki, kj) % SLOTS;
            have_tomb = 0;
            tomb = 0;
            hit = 0;
            where = 0;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (occupied[idx])
                begin
                    if (owner_i[idx] == ki && owner_j[idx] == kj)
                    begin
                        where = idx;
                        hit = 1;
                        return 1;
                    end
                end
                else if (tombstone[idx])
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1;
                        tomb = idx;
                    end
                end
                else
                begin
                    where = have_tomb ? tomb : idx;
                    return 1;
                end
                idx = (idx + 1) % SLOTS;
            end
            where = tomb;
            return have_tomb;
        endfunction

        function void note_request(cmd_t cmd, logic [15:0] ki, logic [15:0] kj,
                                   logic [7:0] cc);
            table_result_t r;
            bit            got;
            bit            hit;
            int            where;
            bit            fresh;
            r.status = ST_NOT_FOUND;
            r.slot_index = '0;
            r.contacts = '0;
            hit = 0;
            where = 0;
            if ((cmd == CMD_GET || cmd == CMD_REMOVE) && used_slots == 0)
                got = 0;
            else
                got = find_slot(ki, kj, where, hit);
            if (cmd == CMD_GET || cmd == CMD_REMOVE)
            begin
                if (got && hit)
                begin
                    r.status = ST_FOUND;
                    r.slot_index = where[9:0];
                    r.contacts = held_contacts[where];
                    if (cmd == CMD_REMOVE)
                    begin
                        occupied[where] = 0;
                        tombstone[where] = 1;
                    end
                end
            end
            else if (got && hit)
            begin
                r.status = ST_FOUND;
                r.slot_index = where[9:0];
                if (cmd == CMD_SET)
                    held_contacts[where] = cc;
                r.contacts = held_contacts[where];
            end
            else if (!got)
                r.status = ST_FULL;
            else
            begin
                fresh = !tombstone[where];
                if (fresh && ((used_slots + 1) * LOAD_SCALE / SLOTS) >= load_limit)
                    r.status = ST_FULL;
                else
                begin
                    if (fresh)
                        used_slots++;
                    occupied[where] = 1;
                    tombstone[where] = 0;
                    owner_i[where] = ki;
                    owner_j[where] = kj;
                    held_contacts[where] = cc;
                    r.status = ST_INSERTED;
                    r.slot_index = where[9:0];
                    r.contacts = cc;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_response(logic [1:0] status, logic [9:0] slot_index,
                                     logic [7:0] contacts);
            table_result_t r;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d slot=%0d contacts=%0d",
                         $time, status, slot_index, contacts);
                errors++;
                return;
            end
            r = awaited.pop_front();
            checked++;
            status_seen[r.status]++;
            if (status !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
            if (slot_index !== r.slot_index)
            begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, r.slot_index, slot_index);
                errors++;
            end
            if (contacts !== r.contacts)
            begin
                $display("%0t: stored_contacts expected %0d actual %0d",
                         $time, r.contacts, contacts);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pkh_req_if req_ch ();
    pkh_rsp_if rsp_ch ();

    pair_key_hash_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pair_table_scoreboard board;

    // idling switches, turned off for some stretches
    bit req_gaps;
    bit rsp_stalls;
    int idle_cycles;
    int requests_sent;
    logic [15:0] pool_i[POOL_SIZE];
    logic [15:0] pool_j[POOL_SIZE];

    always #4 clk = ~clk;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_GET;
        req_ch.key_i = '0;
        req_ch.key_j = '0;
        req_ch.contact_count = '0;
        rsp_ch.ready = 1'b0;
        req_gaps = 1'b1;
        rsp_stalls = 1'b1;
        board = new();
    end

    // watchdog: cycles with no request or response moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d responses outstanding",
                         $time, board.awaited.size());
                $display("Some tests failed");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // response side: random stall before each response, then take it
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = rsp_stalls ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            board.check_response(rsp_ch.status, rsp_ch.slot_index, rsp_ch.stored_contacts);
        end
    end

    // one request, held until the block takes it
    task automatic send_request(cmd_t cmd, logic [15:0] ki, logic [15:0] kj,
                                logic [7:0] cc);
        int gap;
        gap = req_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.key_i <= ki;
        req_ch.key_j <= kj;
        req_ch.contact_count <= cc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(cmd, ki, kj, cc);
        requests_sent++;
    endtask

    // apb write of the load limit, then read back
    task automatic set_load_limit(logic [LIMIT_W-1:0] pct);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * REG_LOAD_LIMIT);
        pwdata <= APB_DATA_W'(pct);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.load_limit = pct;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[LIMIT_W-1:0] !== pct)
        begin
            $display("%0t: load limit read expected %0d actual %0d",
                     $time, pct, prdata[LIMIT_W-1:0]);
            board.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // block is idle once every response is back plus a short settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_requests(int count);
        cmd_t        cmd;
        logic [15:0] ki;
        logic [15:0] kj;
        logic [7:0]  cc;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            // flip idling now and then so some stretches run back to back
            if (n % 40 == 0)
            begin
                req_gaps = ($urandom_range(0, 3) != 0);
                rsp_stalls = ($urandom_range(0, 3) != 0);
            end
            cmd = cmd_t'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
            begin
                ki = 16'($urandom);
                kj = 16'($urandom);
            end
            else
            begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                ki = pool_i[pick];
                kj = pool_j[pick];
            end
            case ($urandom_range(0, 9))
                0: cc = 8'h00;
                1: cc = 8'hff;
                default: cc = 8'($urandom);
            endcase
            send_request(cmd, ki, kj, cc);
        end
    endtask

    initial
    begin
        requests_sent = 0;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_i[p] = 16'($urandom_range(0, 300));
            pool_j[p] = 16'($urandom);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, insert, overwrite, tombstones, key extremes
        send_request(CMD_GET, 16'd5, 16'd9, 8'd0);
        send_request(CMD_REMOVE, 16'd5, 16'd9, 8'd0);
        send_request(CMD_SET, 16'd5, 16'd9, 8'h00);
        send_request(CMD_SET, 16'd5, 16'd9, 8'hff);
        send_request(CMD_GET_INS, 16'd5, 16'd9, 8'd17);
        send_request(CMD_GET, 16'd5, 16'd9, 8'd0);
        send_request(CMD_GET_INS, 16'h0000, 16'h0000, 8'd1);
        send_request(CMD_GET_INS, 16'hffff, 16'hffff, 8'hff);
        send_request(CMD_GET, 16'hffff, 16'h0000, 8'd0);
        send_request(CMD_REMOVE, 16'd5, 16'd9, 8'd0);
        send_request(CMD_GET, 16'd5, 16'd9, 8'd0);
        send_request(CMD_REMOVE, 16'd5, 16'd9, 8'd0);
        send_request(CMD_SET, 16'd5, 16'd9, 8'd3);
        send_request(CMD_REMOVE, 16'h0000, 16'h0000, 8'd0);
        send_request(CMD_GET_INS, 16'h0000, 16'h0000, 8'd200);
        drain();

        // tightest limit: fresh inserts refused after ten entries, reuse still allowed
        set_load_limit(7'd1);
        for (int n = 0; n < 10; n++)
            send_request(CMD_GET_INS, 16'(100 + n), 16'(7000 + n), 8'(n));
        send_request(CMD_REMOVE, 16'd100, 16'd7000, 8'd0);
        send_request(CMD_SET, 16'd100, 16'd7000, 8'd55);
        send_request(CMD_SET, 16'hffff, 16'hffff, 8'd9);
        drain();

        set_load_limit(7'd100);
        random_requests(250);
        drain();

        set_load_limit(7'd50);
        random_requests(250);
        drain();

        $display("covered %0d requests over load limits 70, 1, 100 and 50", requests_sent);
        $display("responses: %0d found, %0d inserted, %0d not found, %0d full",
                 board.status_seen[ST_FOUND], board.status_seen[ST_INSERTED],
                 board.status_seen[ST_NOT_FOUND], board.status_seen[ST_FULL]);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
